// ===== sv/ima_adpcm_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// ima_adpcm_decoder_assert.svh
// assertion macros used by the decoder back end
// ----------------------------------------------------------------------------
`ifndef IMA_ADPCM_DECODER_ASSERT_SVH
`define IMA_ADPCM_DECODER_ASSERT_SVH

// checked property, off while reset is held
`define IMADEC_CHECK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked property, live during reset as well
`define IMADEC_CHECK_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/imadec_pkg.sv =====
// ----------------------------------------------------------------------------
// imadec_pkg
// types, tables and constants of the ima adpcm decoder
// ----------------------------------------------------------------------------
package imadec_pkg;

    localparam int unsigned MAX_INDEX  = 88;
    localparam int unsigned NUM_STEPS  = MAX_INDEX + 1;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic signed [17:0] SAMPLE_MAX = 18'sd32767;
    localparam logic signed [17:0] SAMPLE_MIN = -18'sd32768;

    typedef enum logic {
        ACT_DECODE = 1'b0,
        ACT_LOAD   = 1'b1
    } t_action;

    typedef struct packed {
        t_action            action;
        logic [3:0]         code;
        logic signed [15:0] predictor;
        logic [6:0]         index;
    } t_cmd;

    localparam logic [14:0] STEP_TABLE [NUM_STEPS] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16,
        15'd17, 15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37,
        15'd41, 15'd45, 15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88,
        15'd97, 15'd107, 15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190,
        15'd209, 15'd230, 15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408,
        15'd449, 15'd494, 15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876,
        15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707,
        15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327,
        15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
        15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
        15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    localparam logic signed [4:0] INDEX_ADJ [8] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

    function automatic logic [14:0] f_step(input logic [6:0] idx);
        logic [14:0] s;
        if (idx > 7'(MAX_INDEX)) begin
            s = STEP_TABLE[MAX_INDEX];
        end else begin
            s = STEP_TABLE[idx];
        end
        return s;
    endfunction

endpackage

// ===== sv/imadec_front.sv =====
// ----------------------------------------------------------------------------
// imadec_front
// accepts input beats, tags each as load or decode, clamps the load index
// and holds the commands in a two-entry queue for the back end
// ----------------------------------------------------------------------------
module imadec_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [31:0]         i_s_axis_tdata,
    input  logic                i_s_axis_tuser,
    output logic                o_q_valid,
    output imadec_pkg::t_cmd    o_q_cmd,
    input  logic                i_q_pop
);
    import imadec_pkg::*;

    t_cmd       r_q [QUEUE_DEPTH];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;
    logic [7:0] w_index;

    assign o_s_axis_tready = (r_count != 2'(QUEUE_DEPTH));
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_q_valid       = (r_count != 2'd0);
    assign w_pop           = i_q_pop && o_q_valid;
    assign o_q_cmd         = r_q[r_rd_ptr];

    always_comb begin
        w_index          = i_s_axis_tdata[27:20];
        w_cmd.action     = t_action'(i_s_axis_tuser);
        w_cmd.code       = i_s_axis_tdata[3:0];
        w_cmd.predictor  = $signed(i_s_axis_tdata[19:4]);
        w_cmd.index      = (w_index > 8'(MAX_INDEX)) ? 7'(MAX_INDEX) : w_index[6:0];
        n_wr_ptr         = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr         = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count          = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// ===== sv/imadec_back.sv =====
// ----------------------------------------------------------------------------
// imadec_back
// runs queued commands against the predictor and step index and holds
// each decoded sample in the output register until it is taken
// ----------------------------------------------------------------------------
`include "ima_adpcm_decoder_assert.svh"

module imadec_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  imadec_pkg::t_cmd    i_q_cmd,
    output logic                o_q_pop,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [15:0]         o_m_axis_tdata
);
    import imadec_pkg::*;

    logic signed [15:0] r_pred, n_pred;
    logic [6:0]         r_index, n_index;
    logic               r_out_valid, n_out_valid;
    logic [15:0]        r_out_sample, n_out_sample;

    logic               w_is_load;
    logic               w_decode;
    logic [14:0]        w_step;
    logic [16:0]        w_delta;
    logic signed [17:0] w_acc;
    logic signed [15:0] w_sat;
    logic signed [8:0]  w_pos;
    logic [6:0]         w_pos_clamped;

    assign w_is_load       = (i_q_cmd.action == ACT_LOAD);
    assign o_q_pop         = i_q_valid && (w_is_load || !r_out_valid || i_m_axis_tready);
    assign w_decode        = o_q_pop && !w_is_load;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_sample;

    always_comb begin
        w_step  = f_step(r_index);
        w_delta = 17'(w_step >> 3)
                + (i_q_cmd.code[2] ? 17'(w_step) : 17'd0)
                + (i_q_cmd.code[1] ? 17'(w_step >> 1) : 17'd0)
                + (i_q_cmd.code[0] ? 17'(w_step >> 2) : 17'd0);
        if (i_q_cmd.code[3]) begin
            w_acc = 18'(r_pred) - $signed({1'b0, w_delta});
        end else begin
            w_acc = 18'(r_pred) + $signed({1'b0, w_delta});
        end
        if (w_acc > SAMPLE_MAX) begin
            w_sat = 16'(SAMPLE_MAX);
        end else if (w_acc < SAMPLE_MIN) begin
            w_sat = 16'(SAMPLE_MIN);
        end else begin
            w_sat = w_acc[15:0];
        end
        w_pos = $signed({2'b00, r_index}) + 9'(INDEX_ADJ[i_q_cmd.code[2:0]]);
        if (w_pos < 9'sd0) begin
            w_pos_clamped = 7'd0;
        end else if (w_pos > 9'sd88) begin
            w_pos_clamped = 7'(MAX_INDEX);
        end else begin
            w_pos_clamped = w_pos[6:0];
        end

        n_pred       = r_pred;
        n_index      = r_index;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_sample = r_out_sample;
        if (o_q_pop && w_is_load) begin
            n_pred  = i_q_cmd.predictor;
            n_index = i_q_cmd.index;
        end else if (w_decode) begin
            n_pred       = w_sat;
            n_index      = w_pos_clamped;
            n_out_valid  = 1'b1;
            n_out_sample = w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred      <= 16'sd0;
            r_index     <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_pred      <= n_pred;
            r_index     <= n_index;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sample <= n_out_sample;
    end

    `IMADEC_CHECK(a_index_range, r_index <= 7'(MAX_INDEX), "step index beyond table")
    `IMADEC_CHECK(a_no_overwrite, (w_decode && r_out_valid) |-> i_m_axis_tready,
        "decode would overwrite an untaken sample")
    `IMADEC_CHECK(a_load_no_beat, (o_q_pop && w_is_load && !r_out_valid) |=> !r_out_valid,
        "load produced an output beat")
    `IMADEC_CHECK_RST(a_reset_empty, !i_rst_n |=> !r_out_valid, "output valid after reset")

endmodule

// ===== sv/ima_adpcm_decoder.sv =====
// ----------------------------------------------------------------------------
// ima_adpcm_decoder
// ima adpcm decoder, 4-bit codes to 16-bit signed pcm
//
//   channel  dir  tdata (low bit up)                          tuser
//   s_axis   in   code[3:0] start_predictor[19:4]             action
//                 start_index[27:20] zero[31:28]
//   m_axis   out  sample[15:0]                                -
//
// one beat per cycle sustained while the output is taken: a decode runs the back end
// (step table, add and saturate) into the output register, a load gives no output beat
// two-entry queue between front and back; one output register holds the sample
// input stalls only when the queue is full, i.e. the output is held off
// synchronous active-low reset clears predictor, step index, queue and output
// ----------------------------------------------------------------------------
module ima_adpcm_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // code, start_predictor, start_index
    input  logic        i_s_axis_tuser,   // action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // sample
);
    import imadec_pkg::*;

    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_pop;

    imadec_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_q_valid       (w_q_valid),
        .o_q_cmd         (w_q_cmd),
        .i_q_pop         (w_q_pop)
    );

    imadec_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_cmd         (w_q_cmd),
        .o_q_pop         (w_q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
